>>> hw/rtl/c7n_pkg.sv
// Shared types and constants for the normalised 7x7 convolution filter.
// No dependencies.
package c7n_pkg;

    localparam int TAPS           = 49;
    localparam int WIN            = 7;
    localparam int LINES          = 6;
    localparam int PIX_W          = 8;
    localparam int COEF_W         = 16;
    localparam int ACC_W          = 32;
    localparam int LW_W           = 11;
    localparam int POS_W          = 10;
    localparam int IDX_W          = 6;
    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 1024;
    localparam int LW_RESET       = 1024;
    localparam logic [PIX_W-1:0] PIX_MAX = 8'hFF;

    localparam logic CMD_COEF  = 1'b0;
    localparam logic CMD_PIXEL = 1'b1;

    localparam logic REG_LINE_WIDTH = 1'b0;

    typedef struct packed {
        logic shift;
        logic rotate;
    } t_cell_ctrl;

endpackage

>>> hw/rtl/conv7x7_u8_normalized_filter.sv
// Normalised 7x7 convolution, top level: line stores, cell chain, MAC, divider.
// A coefficient beat is taken in idle; a pixel beat passes read and shift, and one that
// yields a result goes on through 49 cell rotations through the single multiplier,
// accumulate, divide and output, and waits in output while the output is stalled.
// One beat in flight at a time.
// Reset (synchronous, active low) clears window, taps, tap sum and position;
// line stores hold no reset value and need no clearing pass.
module conv7x7_u8_normalized_filter #(
    parameter int MAX_WIDTH  = c7n_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = c7n_pkg::DEF_MAX_HEIGHT
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready,
    input  logic         i_in_valid,
    output logic         o_in_ready,
    input  logic         i_command,
    input  logic [5:0]   i_coeff_index,
    input  logic signed [15:0] i_coeff_value,
    input  logic [7:0]   i_pixel,
    input  logic         i_frame_start,
    output logic         o_out_valid,
    input  logic         i_out_ready,
    output logic [7:0]   o_out_value,
    output logic [9:0]   o_out_col,
    output logic [9:0]   o_out_row
);
    import c7n_pkg::*;

    localparam int CW  = $clog2(MAX_WIDTH);
    localparam int RW  = $clog2(MAX_HEIGHT);
    localparam int WW  = ($clog2(MAX_WIDTH + 1) > LW_W) ? $clog2(MAX_WIDTH + 1) : LW_W;
    localparam int MW  = LINES * PIX_W;

    typedef enum logic [6:0] {
        ST_IDLE = 7'b0000001,
        ST_RD   = 7'b0000010,
        ST_SH   = 7'b0000100,
        ST_MAC  = 7'b0001000,
        ST_ACC  = 7'b0010000,
        ST_DIV  = 7'b0100000,
        ST_OUT  = 7'b1000000
    } t_state;

    t_state               r_state, n_state;
    logic [LW_W-1:0]      r_lw;
    logic [CW-1:0]        r_col;
    logic [RW-1:0]        r_row;
    logic [PIX_W-1:0]     r_pix;
    logic [COEF_W-1:0]    r_ksum;
    logic [MW-1:0]        r_mem [MAX_WIDTH];
    logic [MW-1:0]        r_rdata;
    logic [5:0]           r_cnt;
    logic signed [24:0]   r_prod;
    logic                 r_pv;
    logic signed [ACC_W-1:0] r_acc;
    logic                 r_dstart;
    logic [POS_W-1:0]     r_ocol, r_orow;
    logic                 r_ovalid;
    logic [PIX_W-1:0]     r_oval;
    logic [POS_W-1:0]     r_ocol_q, r_orow_q;

    logic                 w_acc_in;
    logic                 w_cfg_wr;
    logic [CW-1:0]        w_col0;
    logic [RW-1:0]        w_row0;
    logic [WW-1:0]        w_lw, w_eff;
    logic                 w_produce;
    logic                 w_coef_ok;
    t_cell_ctrl           w_ctrl;
    logic [PIX_W-1:0]     w_pix   [TAPS];
    logic signed [COEF_W-1:0] w_coef [TAPS];
    logic [PIX_W-1:0]     w_colpix [WIN];
    logic                 w_div_done;
    logic [PIX_W-1:0]     w_quot;
    logic [COEF_W-1:0]    w_divisor;
    logic                 w_out_free;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite;
    assign prdata   = (paddr[2] == REG_LINE_WIDTH) ? {21'd0, r_lw} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lw <= LW_W'(LW_RESET);
        end else if (w_cfg_wr && paddr[2] == REG_LINE_WIDTH) begin
            r_lw <= pwdata[LW_W-1:0];
        end
    end

    assign o_in_ready = (r_state == ST_IDLE);
    assign w_acc_in   = i_in_valid && o_in_ready;
    assign w_coef_ok  = (i_coeff_index < IDX_W'(TAPS));
    assign w_col0     = i_frame_start ? '0 : r_col;
    assign w_row0     = i_frame_start ? '0 : r_row;

    assign w_lw  = WW'(r_lw);
    assign w_eff = (w_lw < WW'(WIN)) ? WW'(WIN) :
                   (w_lw > WW'(MAX_WIDTH)) ? WW'(MAX_WIDTH) : w_lw;
    assign w_produce = (r_col >= CW'(LINES)) && (r_row >= RW'(LINES));

    // window control
    assign w_ctrl.shift  = (r_state == ST_SH);
    assign w_ctrl.rotate = (r_state == ST_MAC);

    for (genvar r = 0; r < WIN; r++) begin : g_colpix
        if (r < LINES) begin : g_st
            assign w_colpix[r] = r_rdata[r*PIX_W +: PIX_W];
        end else begin : g_new
            assign w_colpix[r] = r_pix;
        end
    end

    for (genvar k = 0; k < TAPS; k++) begin : g_cell
        logic [PIX_W-1:0] w_src;
        if ((k % WIN) == WIN - 1) begin : g_edge
            assign w_src = w_colpix[k / WIN];
        end else begin : g_mid
            assign w_src = w_pix[k + 1];
        end
        c7n_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctrl      (w_ctrl),
            .i_coef_we   (w_acc_in && i_command == CMD_COEF &&
                          i_coeff_index == IDX_W'(k)),
            .i_coef_wval (i_coeff_value),
            .i_shift_pix (w_src),
            .i_nb_pix    (w_pix[(k + 1) % TAPS]),
            .i_nb_coef   (w_coef[(k + 1) % TAPS]),
            .o_pix       (w_pix[k]),
            .o_coef      (w_coef[k])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ksum <= '0;
        end else if (w_acc_in && i_command == CMD_COEF && w_coef_ok) begin
            r_ksum <= r_ksum - $unsigned(w_coef[i_coeff_index]) + $unsigned(i_coeff_value);
        end
    end

    // line stores
    always_ff @(posedge i_clk) begin
        if (w_acc_in) begin
            r_rdata <= r_mem[w_col0];
        end
        if (r_state == ST_SH) begin
            r_mem[r_col] <= {r_pix, r_rdata[MW-1:PIX_W]};
        end
    end

    // position and pixel capture
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (w_acc_in && i_command == CMD_PIXEL) begin
            r_col <= w_col0;
            r_row <= w_row0;
        end else if (r_state == ST_SH) begin
            if (WW'(r_col) + WW'(1) >= w_eff) begin
                r_col <= '0;
                r_row <= ((RW+1)'(r_row) + (RW+1)'(1) >= (RW+1)'(MAX_HEIGHT)) ?
                         '0 : r_row + RW'(1);
            end else begin
                r_col <= r_col + CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc_in) begin
            r_pix <= i_pixel;
        end
        if (r_state == ST_SH) begin
            r_ocol <= POS_W'((CW+POS_W)'(r_col) - (CW+POS_W)'(3));
            r_orow <= POS_W'((RW+POS_W)'(r_row) - (RW+POS_W)'(3));
        end
    end

    // MAC over the rotating chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv <= 1'b0;
        end else begin
            r_pv <= (r_state == ST_MAC);
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= $signed({1'b0, w_pix[0]}) * w_coef[0];
        if (r_state == ST_SH) begin
            r_acc <= '0;
            r_cnt <= '0;
        end else begin
            if (r_pv) begin
                r_acc <= r_acc + ACC_W'(r_prod);
            end
            if (r_state == ST_MAC) begin
                r_cnt <= r_cnt + 6'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dstart <= 1'b0;
        end else begin
            r_dstart <= (r_state == ST_ACC);
        end
    end

    assign w_divisor = (r_ksum == '0) ? COEF_W'(1) : r_ksum;

    c7n_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_dstart),
        .i_dividend (r_acc),
        .i_divisor  (w_divisor),
        .o_done     (w_div_done),
        .o_quot     (w_quot)
    );

    // sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (w_acc_in && i_command == CMD_PIXEL) n_state = ST_RD;
            ST_RD:   n_state = ST_SH;
            ST_SH:   n_state = w_produce ? ST_MAC : ST_IDLE;
            ST_MAC:  if (r_cnt == 6'(TAPS - 1)) n_state = ST_ACC;
            ST_ACC:  n_state = ST_DIV;
            ST_DIV:  if (w_div_done) n_state = ST_OUT;
            ST_OUT:  if (w_out_free) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // output register
    assign w_out_free = !r_ovalid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (r_state == ST_OUT && w_out_free) begin
            r_ovalid <= 1'b1;
        end else if (i_out_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_OUT && w_out_free) begin
            r_oval   <= w_quot;
            r_ocol_q <= r_ocol;
            r_orow_q <= r_orow;
        end
    end

    assign o_out_valid = r_ovalid;
    assign o_out_value = r_oval;
    assign o_out_col   = r_ocol_q;
    assign o_out_row   = r_orow_q;

endmodule

>>> hw/rtl/c7n_cell.sv
// One window cell: a pixel and its tap, shifted or rotated along the chain.
// Depends on c7n_pkg.
module c7n_cell (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  c7n_pkg::t_cell_ctrl         i_ctrl,
    input  logic                        i_coef_we,
    input  logic signed [15:0]          i_coef_wval,
    input  logic [7:0]                  i_shift_pix,
    input  logic [7:0]                  i_nb_pix,
    input  logic signed [15:0]          i_nb_coef,
    output logic [7:0]                  o_pix,
    output logic signed [15:0]          o_coef
);
    import c7n_pkg::*;

    logic [PIX_W-1:0]         r_pix;
    logic signed [COEF_W-1:0] r_coef;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pix  <= '0;
            r_coef <= '0;
        end else if (i_ctrl.rotate) begin
            r_pix  <= i_nb_pix;
            r_coef <= i_nb_coef;
        end else begin
            if (i_ctrl.shift) begin
                r_pix <= i_shift_pix;
            end
            if (i_coef_we) begin
                r_coef <= i_coef_wval;
            end
        end
    end

    assign o_pix  = r_pix;
    assign o_coef = r_coef;

endmodule

>>> hw/rtl/c7n_div.sv
// Normalising divider: clamped 8-bit quotient, one bit per cycle.
// Depends on c7n_pkg.
module c7n_div (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic signed [31:0]       i_dividend,
    input  logic [15:0]              i_divisor,
    output logic                     o_done,
    output logic [7:0]               o_quot
);
    import c7n_pkg::*;

    localparam int REM_W = COEF_W + PIX_W;

    logic               r_busy;
    logic               r_done;
    logic [2:0]         r_k;
    logic [REM_W-1:0]   r_rem;
    logic [COEF_W-1:0]  r_div;
    logic [PIX_W-1:0]   r_q;
    logic               r_neg;
    logic               r_sat;
    logic [REM_W-1:0]   w_trial;
    logic [ACC_W-1:0]   w_lim;

    assign w_trial = REM_W'(r_div) << r_k;
    assign w_lim   = ACC_W'({i_divisor, 8'h00});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_k == 3'd0) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_neg <= i_dividend[ACC_W-1];
            r_sat <= !i_dividend[ACC_W-1] && $unsigned(i_dividend) >= w_lim;
            r_rem <= i_dividend[REM_W-1:0];
            r_div <= i_divisor;
            r_k   <= 3'd7;
            r_q   <= '0;
        end else if (r_busy) begin
            if (r_rem >= w_trial) begin
                r_rem      <= r_rem - w_trial;
                r_q[r_k]   <= 1'b1;
            end
            r_k <= r_k - 3'd1;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_neg ? '0 : (r_sat ? PIX_MAX : r_q);

endmodule

>>> bench/tb.sv
// Self-checking bench for the normalised 7x7 convolution filter.
// Drives tap-load and pixel beats and checks results against a local predictor.
// Depends on c7n_pkg and conv7x7_u8_normalized_filter.
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import c7n_pkg::*;

    localparam int CYCLE_LIMIT = 3000000;
    localparam int SETTLE      = 100;

    typedef struct packed {
        logic [7:0] value;
        logic [9:0] col;
        logic [9:0] row;
    } t_pix_out;

    logic        i_clk;
    logic        i_rst_n;
    logic        psel, penable, pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        i_in_valid;
    logic        o_in_ready;
    logic        i_command;
    logic [5:0]  i_coeff_index;
    logic signed [15:0] i_coeff_value;
    logic [7:0]  i_pixel;
    logic        i_frame_start;
    logic        o_out_valid;
    logic        i_out_ready;
    logic [7:0]  o_out_value;
    logic [9:0]  o_out_col;
    logic [9:0]  o_out_row;

    conv7x7_u8_normalized_filter DUT (.*);

    // Predictor state
    logic [7:0]  line_mem [LINES][DEF_MAX_WIDTH];
    logic [7:0]  win [TAPS];
    logic [15:0] taps [TAPS];
    logic [15:0] tap_sum;
    int unsigned col_pos, row_pos;
    logic [10:0] width_reg;

    t_pix_out    pending_pix[$];
    int          errors;
    int          cycles;
    bit          no_gaps;
    int          rx_stall;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (no_gaps) return 0;
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(3, 1);
        return $urandom_range(40, 10);
    endfunction

    function automatic void predict_reset();
        foreach (line_mem[k, c]) line_mem[k][c] = 8'd0;
        foreach (win[k]) win[k] = 8'd0;
        foreach (taps[k]) taps[k] = 16'd0;
        tap_sum = 16'd0;
        col_pos = 0;
        row_pos = 0;
        width_reg = 11'(LW_RESET);
    endfunction

    function automatic void predict_beat(logic cmd, logic [5:0] idx, logic [15:0] cval,
                                         logic [7:0] pix, logic fs);
        int unsigned w, c;
        logic [7:0] column [WIN];
        longint acc, dv, q;
        t_pix_out res;
        if (cmd == CMD_COEF) begin
            if (idx < TAPS) begin
                tap_sum = tap_sum - taps[idx] + cval;
                taps[idx] = cval;
            end
            return;
        end
        if (fs) begin
            col_pos = 0;
            row_pos = 0;
        end
        w = (width_reg < 7) ? 7 : (width_reg > DEF_MAX_WIDTH) ? DEF_MAX_WIDTH : width_reg;
        c = (col_pos >= DEF_MAX_WIDTH) ? DEF_MAX_WIDTH - 1 : col_pos;
        for (int k = 0; k < LINES; k++) column[k] = line_mem[k][c];
        column[WIN-1] = pix;
        for (int k = 0; k < LINES - 1; k++) line_mem[k][c] = line_mem[k+1][c];
        line_mem[LINES-1][c] = pix;
        for (int r = 0; r < WIN; r++) begin
            for (int k = 0; k < WIN - 1; k++) win[r*WIN+k] = win[r*WIN+k+1];
            win[r*WIN+WIN-1] = column[r];
        end
        if (col_pos >= 6 && row_pos >= 6) begin
            acc = 0;
            for (int k = 0; k < TAPS; k++)
                acc += longint'(win[k]) * longint'($signed(taps[k]));
            dv = (tap_sum == 0) ? 1 : longint'(tap_sum);
            q = acc / dv;
            if (q < 0) q = 0;
            if (q > 255) q = 255;
            res.value = q[7:0];
            res.col = 10'(col_pos - 3);
            res.row = 10'(row_pos - 3);
            pending_pix.push_back(res);
        end
        if (col_pos + 1 >= w) begin
            col_pos = 0;
            row_pos = (row_pos + 1 >= DEF_MAX_HEIGHT) ? 0 : row_pos + 1;
        end else begin
            col_pos = col_pos + 1;
        end
    endfunction

    task automatic send_beat(logic cmd, logic [5:0] idx, logic [15:0] cval,
                             logic [7:0] pix, logic fs);
        int gap;
        gap = pick_gap();
        @(negedge i_clk);
        if (gap > 0) begin
            i_in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_command = cmd;
        i_coeff_index = idx;
        i_coeff_value = cval;
        i_pixel = pix;
        i_frame_start = fs;
        i_in_valid = 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
        predict_beat(cmd, idx, cval, pix, fs);
    endtask

    task automatic drain();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (pending_pix.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_width(logic [10:0] w);
        drain();
        @(negedge i_clk);
        psel = 1'b1; pwrite = 1'b1; paddr = 3'(4 * REG_LINE_WIDTH); pwdata = 32'(w);
        @(negedge i_clk);
        penable = 1'b1;
        @(negedge i_clk);
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
        width_reg = w;
    endtask

    // mode 0: small non-negative taps, 1: full random, 2: centre only, 3: all zero
    task automatic load_kernel(int mode, logic [15:0] centre);
        logic [15:0] v;
        for (int k = 0; k < TAPS; k++) begin
            case (mode)
                0: v = 16'($urandom_range(20));
                1: v = 16'($urandom);
                2: v = (k == TAPS / 2) ? centre : 16'd0;
                default: v = 16'd0;
            endcase
            send_beat(CMD_COEF, 6'(k), v, 8'($urandom), 1'($urandom));
        end
    endtask

    // pmode 0: random, 1: all 0xFF, 2: all zero, 3: mixed extremes
    task automatic send_frame(int w, int h, int pmode);
        logic [7:0] p;
        for (int i = 0; i < w * h; i++) begin
            case (pmode)
                0: p = 8'($urandom);
                1: p = PIX_MAX;
                2: p = 8'd0;
                default: p = $urandom_range(1) ? PIX_MAX : 8'd0;
            endcase
            send_beat(CMD_PIXEL, 6'($urandom), 16'($urandom), p, i == 0);
        end
    endtask

    task automatic test_identity();
        write_width(11'd7);
        load_kernel(2, 16'd1);
        send_frame(7, 8, 0);
        send_frame(7, 7, 1);
        send_frame(7, 7, 2);
    endtask

    task automatic test_clamp();
        load_kernel(2, 16'h8000);
        send_frame(7, 7, 1);
        load_kernel(2, 16'h7FFF);
        send_beat(CMD_COEF, 6'd0, 16'hFFFF, 8'd0, 1'b0);
        send_frame(8, 8, 3);
    endtask

    task automatic test_zero_sum();
        load_kernel(3, 16'd0);
        send_beat(CMD_COEF, 6'd24, 16'd2, 8'd0, 1'b0);
        send_beat(CMD_COEF, 6'd25, 16'hFFFE, 8'd0, 1'b0);
        send_frame(7, 7, 0);
        send_beat(CMD_COEF, 6'd25, 16'h7FFF, 8'd0, 1'b0);
        send_beat(CMD_COEF, 6'd26, 16'h7FFF, 8'd0, 1'b0);
        send_frame(7, 7, 3);
    endtask

    task automatic test_bad_index();
        load_kernel(0, 16'd0);
        send_beat(CMD_COEF, 6'd63, 16'h1234, 8'd0, 1'b1);
        send_beat(CMD_COEF, 6'd49, 16'h8001, 8'd0, 1'b0);
        send_beat(CMD_COEF, 6'd48, 16'd5, 8'd0, 1'b1);
        send_frame(9, 8, 0);
    endtask

    task automatic test_width_limits();
        write_width(11'd0);
        send_frame(7, 8, 0);
        write_width(11'd2047);
        send_frame(30, 1, 0);
        write_width(11'd1024);
        send_frame(20, 1, 0);
        write_width(11'd3);
        send_frame(7, 7, 0);
    endtask

    task automatic test_width_shrink();
        write_width(11'd12);
        load_kernel(0, 16'd0);
        send_frame(12, 7, 0);
        for (int i = 0; i < 9; i++)
            send_beat(CMD_PIXEL, 6'd0, 16'd0, 8'($urandom), 1'b0);
        write_width(11'd8);
        for (int i = 0; i < 24; i++)
            send_beat(CMD_PIXEL, 6'd0, 16'd0, 8'($urandom), 1'b0);
        for (int i = 0; i < 3; i++)
            send_beat(CMD_PIXEL, 6'd0, 16'd0, 8'($urandom), 1'b0);
        write_width(11'd7);
        for (int i = 0; i < 14; i++)
            send_beat(CMD_PIXEL, 6'd0, 16'd0, 8'($urandom), 1'b0);
    endtask

    task automatic test_random();
        int sent;
        int w, h;
        sent = 0;
        while (sent < 700) begin
            if ($urandom_range(3) == 0) begin
                w = $urandom_range(3) == 0 ? $urandom_range(40, 7) : $urandom_range(12, 7);
                write_width(11'(w));
            end else begin
                w = (width_reg < 7) ? 7 : width_reg;
            end
            if ($urandom_range(2) == 0) begin
                load_kernel($urandom_range(4) == 0 ? 1 : 0, 16'd0);
                sent += TAPS;
            end
            if ($urandom_range(4) == 0) begin
                send_beat(CMD_COEF, 6'($urandom_range(63, 49)), 16'($urandom), 8'd0, 1'b0);
                send_beat(CMD_COEF, 6'($urandom_range(48)), 16'($urandom), 8'd0, 1'($urandom));
                sent += 2;
            end
            no_gaps = ($urandom_range(4) == 0);
            h = $urandom_range(9, 7);
            send_frame(w, h, $urandom_range(5) == 0 ? 3 : 0);
            sent += w * h;
            if ($urandom_range(3) == 0) begin
                for (int i = 0; i < w; i++)
                    send_beat(CMD_PIXEL, 6'd0, 16'd0, 8'($urandom), 1'b0);
                sent += w;
            end
            no_gaps = 1'b0;
        end
    endtask

    always @(negedge i_clk) begin
        if (rx_stall > 0) begin
            rx_stall--;
            i_out_ready = 1'b0;
        end else begin
            rx_stall = pick_gap();
            i_out_ready = (rx_stall == 0);
        end
    end

    always @(posedge i_clk) begin
        t_pix_out want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_pix.size() == 0) begin
                $display("%0t: unexpected result value=%0d col=%0d row=%0d",
                         $time, o_out_value, o_out_col, o_out_row);
                errors++;
            end else begin
                want = pending_pix.pop_front();
                if (o_out_value !== want.value) begin
                    $display("%0t: value expected %0d actual %0d", $time, want.value,
                             o_out_value);
                    errors++;
                end
                if (o_out_col !== want.col) begin
                    $display("%0t: col expected %0d actual %0d", $time, want.col, o_out_col);
                    errors++;
                end
                if (o_out_row !== want.row) begin
                    $display("%0t: row expected %0d actual %0d", $time, want.row, o_out_row);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb failed");
            $finish;
        end
    end

    initial begin
        i_clk = 1'b0;
        errors = 0;
        cycles = 0;
        no_gaps = 1'b0;
        rx_stall = 0;
        i_rst_n = 1'b0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        i_in_valid = 1'b0;
        i_command = CMD_PIXEL;
        i_coeff_index = '0;
        i_coeff_value = '0;
        i_pixel = '0;
        i_frame_start = 1'b0;
        i_out_ready = 1'b1;
        predict_reset();
        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;

        send_frame(10, 2, 0);
        test_identity();
        test_clamp();
        test_zero_sum();
        test_bad_index();
        test_width_limits();
        test_width_shrink();
        test_random();

        drain();
        if (errors == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end
endmodule

>>> conv7x7_u8_normalized_filter.f
hw/rtl/c7n_pkg.sv
hw/rtl/c7n_cell.sv
hw/rtl/c7n_div.sv
hw/rtl/conv7x7_u8_normalized_filter.sv
bench/tb.sv
